### rtl/lvc_pkg.sv
// Shared types and constants for the value cache.
// Holds the outcome codes, field widths and the scan item passed along the cell row.
// No dependencies.
package lvc_pkg;

	localparam int VALUE_W = 32;
	localparam int OUTCOME_W = 2;
	localparam int SLOT_W = 3;
	localparam int CFG_W = 4;
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	localparam int DEF_MAX_ENTRIES = 8;
	localparam int DEF_STAMP_WIDTH = 32;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_HIT,
		OUT_FILL,
		OUT_REPLACE
	} outcome_t;

	typedef struct packed {
		logic valid;
		logic found;
		outcome_t kind;
		logic [VALUE_W-1:0] prev;
		logic [VALUE_W-1:0] req;
		logic [VALUE_W-1:0] oldest_value;
	} scan_t;

endpackage

### rtl/lvc_cell.sv
// One cache entry: stored value and last-use stamp.
// Examines the passing scan item, updates it and hands it to the next cell.
// Depends on lvc_pkg.
module lvc_cell #(
	parameter int IDX = 0,
	parameter int IDX_W = 3,
	parameter int STAMP_WIDTH = lvc_pkg::DEF_STAMP_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       active,
	input  lvc_pkg::scan_t             scan_i,
	input  logic [IDX_W-1:0]           slot_i,
	input  logic [IDX_W-1:0]           old_idx_i,
	input  logic [STAMP_WIDTH-1:0]     old_stamp_i,
	output lvc_pkg::scan_t             scan_o,
	output logic [IDX_W-1:0]           slot_o,
	output logic [IDX_W-1:0]           old_idx_o,
	output logic [STAMP_WIDTH-1:0]     old_stamp_o,
	input  logic                       wr_en,
	input  logic [IDX_W-1:0]           wr_slot,
	input  logic [lvc_pkg::VALUE_W-1:0] wr_value,
	input  logic [STAMP_WIDTH-1:0]     wr_stamp
);
	import lvc_pkg::*;

	logic [VALUE_W-1:0] value_q;
	logic [STAMP_WIDTH-1:0] stamp_q;
	scan_t scan_d, scan_q;
	logic [IDX_W-1:0] slot_d, slot_q, old_idx_d, old_idx_q;
	logic [STAMP_WIDTH-1:0] old_stamp_d, old_stamp_q;

	always_comb begin
		scan_d = scan_i;
		slot_d = slot_i;
		old_idx_d = old_idx_i;
		old_stamp_d = old_stamp_i;
		if (active && !scan_i.found) begin
			if (IDX == 0 || stamp_q < old_stamp_i) begin
				old_idx_d = IDX_W'(IDX);
				old_stamp_d = stamp_q;
				scan_d.oldest_value = value_q;
			end
			if (value_q == scan_i.req) begin
				scan_d.found = 1'b1;
				scan_d.kind = OUT_HIT;
				scan_d.prev = value_q;
				slot_d = IDX_W'(IDX);
			end else if (value_q == '0) begin
				scan_d.found = 1'b1;
				scan_d.kind = OUT_FILL;
				scan_d.prev = '0;
				slot_d = IDX_W'(IDX);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else begin
			scan_q <= scan_d;
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_d;
		old_idx_q <= old_idx_d;
		old_stamp_q <= old_stamp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			stamp_q <= '0;
		end else if (wr_en && wr_slot == IDX_W'(IDX)) begin
			value_q <= wr_value;
			stamp_q <= wr_stamp;
		end
	end

	assign scan_o = scan_q;
	assign slot_o = slot_q;
	assign old_idx_o = old_idx_q;
	assign old_stamp_o = old_stamp_q;

endmodule

### rtl/lru_value_cache.sv
// Fully associative value cache with least recently used replacement.
// Top level: row of lvc_cell entries, request clock, result register, config register.
// Depends on lvc_pkg and lvc_cell.
//
// Request channel: req_valid / req_stall with request_value. Result channel:
// rsp_valid / rsp_stall with outcome, slot_index and previous_value.
// An accepted item enters the first cell and moves one cell per cycle down the
// row of MAX_ENTRIES cells; each cell compares its entry and tracks the oldest
// stamp. The finished item is held at the row's end; when it commits, the
// result is registered, and at that edge the chosen entry is written and the
// request clock advances. One item is in flight at a time: a new item is taken
// the cycle after the previous one commits, so no new request is accepted
// until the last one has committed.
// If the receiver stalls, the finished item waits at the row's end until the
// result register frees; req_stall stays high meanwhile.
// Reset empties all entries, clears stamps, sets the request clock to one and
// active_entries to eight. cfg_we writes active_entries; write it only while idle.
module lru_value_cache #(
	parameter int MAX_ENTRIES = lvc_pkg::DEF_MAX_ENTRIES,
	parameter int STAMP_WIDTH = lvc_pkg::DEF_STAMP_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lvc_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic signed [lvc_pkg::VALUE_W-1:0] request_value,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [lvc_pkg::OUTCOME_W-1:0]      outcome,
	output logic [lvc_pkg::SLOT_W-1:0]         slot_index,
	output logic signed [lvc_pkg::VALUE_W-1:0] previous_value
);
	import lvc_pkg::*;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	logic [CFG_W-1:0] active_entries_q;
	logic [STAMP_WIDTH-1:0] request_clock_q;
	logic busy_q;
	logic accept, commit;

	scan_t scan_c [MAX_ENTRIES+1];
	logic [IDX_W-1:0] slot_c [MAX_ENTRIES+1];
	logic [IDX_W-1:0] old_idx_c [MAX_ENTRIES+1];
	logic [STAMP_WIDTH-1:0] old_stamp_c [MAX_ENTRIES+1];
	logic [MAX_ENTRIES-1:0] active;
	logic [MAX_ENTRIES-1:0] row_valid;

	scan_t fin_q;
	logic fin_valid_q;
	logic [IDX_W-1:0] fin_slot_q, fin_old_idx_q;

	logic wr_en;
	logic [IDX_W-1:0] wr_slot;
	logic [VALUE_W-1:0] wr_prev;
	outcome_t wr_kind;

	assign req_stall = busy_q;
	assign accept = req_valid && !req_stall;

	always_comb begin
		scan_c[0] = '0;
		scan_c[0].valid = accept;
		scan_c[0].kind = OUT_REPLACE;
		scan_c[0].req = request_value;
		slot_c[0] = '0;
		old_idx_c[0] = '0;
		old_stamp_c[0] = '0;
	end

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		assign active[i] = (i == 0) || (32'(i) < 32'(active_entries_q));
		assign row_valid[i] = scan_c[i+1].valid;

		lvc_cell #(
			.IDX(i),
			.IDX_W(IDX_W),
			.STAMP_WIDTH(STAMP_WIDTH)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.active(active[i]),
			.scan_i(scan_c[i]),
			.slot_i(slot_c[i]),
			.old_idx_i(old_idx_c[i]),
			.old_stamp_i(old_stamp_c[i]),
			.scan_o(scan_c[i+1]),
			.slot_o(slot_c[i+1]),
			.old_idx_o(old_idx_c[i+1]),
			.old_stamp_o(old_stamp_c[i+1]),
			.wr_en(wr_en),
			.wr_slot(wr_slot),
			.wr_value(fin_q.req),
			.wr_stamp(request_clock_q)
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_q <= 1'b0;
		end else if (scan_c[MAX_ENTRIES].valid) begin
			fin_valid_q <= 1'b1;
		end else if (commit) begin
			fin_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_c[MAX_ENTRIES].valid) begin
			fin_q <= scan_c[MAX_ENTRIES];
			fin_slot_q <= slot_c[MAX_ENTRIES];
			fin_old_idx_q <= old_idx_c[MAX_ENTRIES];
		end
	end

	assign commit = fin_valid_q && (!rsp_valid || !rsp_stall);
	assign wr_en = commit;
	assign wr_slot = fin_q.found ? fin_slot_q : fin_old_idx_q;
	assign wr_prev = fin_q.found ? fin_q.prev : fin_q.oldest_value;
	assign wr_kind = fin_q.found ? fin_q.kind : OUT_REPLACE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rsp_valid <= 1'b0;
			request_clock_q <= STAMP_WIDTH'(1);
			active_entries_q <= CFG_RESET;
		end else begin
			if (cfg_we) begin
				active_entries_q <= cfg_wdata;
			end
			if (accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				rsp_valid <= 1'b1;
				if (request_clock_q != '1) begin
					request_clock_q <= request_clock_q + STAMP_WIDTH'(1);
				end
			end else if (!rsp_stall) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			outcome <= OUTCOME_W'(wr_kind);
			slot_index <= SLOT_W'(wr_slot);
			previous_value <= wr_prev;
		end
	end

	a_commit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> busy_q)
		else $error("entry written with no item in flight");

	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({fin_valid_q, row_valid}))
		else $error("more than one item in the cell row");

	a_clock_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		request_clock_q != '0)
		else $error("request clock wrapped to zero");

	a_enter_row: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> scan_c[1].valid)
		else $error("accepted item did not enter the first cell");

endmodule

### bench/lvc_checker.sv
`timescale 1ns / 100ps
// Checker for lru_value_cache: keeps its own copy of the entry store, stamps and request
// clock, predicts each lookup result and compares it with the result channel.
// Depends on lvc_pkg.
module lvc_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lvc_pkg::CFG_W-1:0]           cfg_wdata,
	input  logic                                req_valid,
	input  logic                                req_stall,
	input  logic signed [lvc_pkg::VALUE_W-1:0]  request_value,
	input  logic                                rsp_valid,
	input  logic                                rsp_stall,
	input  logic [lvc_pkg::OUTCOME_W-1:0]       outcome,
	input  logic [lvc_pkg::SLOT_W-1:0]          slot_index,
	input  logic signed [lvc_pkg::VALUE_W-1:0]  previous_value,
	output int                                  fail_count,
	output int                                  pending
);
	import lvc_pkg::*;

	localparam int ENTRIES = DEF_MAX_ENTRIES;
	localparam int STAMP_W = DEF_STAMP_WIDTH;

	typedef struct packed {
		outcome_t kind;
		logic [SLOT_W-1:0] slot;
		logic [VALUE_W-1:0] prev;
	} lookup_t;

	logic [VALUE_W-1:0] entry_val [ENTRIES];
	logic [STAMP_W-1:0] entry_stamp [ENTRIES];
	logic [STAMP_W-1:0] req_clock;
	logic [CFG_W-1:0] active_cfg;
	lookup_t lookup_q [$];
	lookup_t want;
	int n_in;
	int n_out;
	int n_fail = 0;

	assign fail_count = n_fail;
	assign pending = n_in - n_out;

	task automatic flag_mismatch(input string what, input logic [VALUE_W-1:0] got_v,
			input logic [VALUE_W-1:0] want_v);
		$display("%0t: mismatch on %s: got %h, want %h", $time, what, got_v, want_v);
		n_fail++;
	endtask

	function automatic lookup_t cache_lookup(input logic [VALUE_W-1:0] req);
		int n;
		int oldest;
		int slot;
		logic found;
		lookup_t r;
		n = int'(active_cfg);
		if (n == 0)
			n = 1;
		if (n > ENTRIES)
			n = ENTRIES;
		oldest = 0;
		slot = 0;
		found = 1'b0;
		r.kind = OUT_REPLACE;
		for (int i = 0; i < n; i++) begin
			if (!found) begin
				if (entry_stamp[i] < entry_stamp[oldest])
					oldest = i;
				if (entry_val[i] == req) begin
					found = 1'b1;
					slot = i;
					r.kind = OUT_HIT;
				end else if (entry_val[i] == '0) begin
					found = 1'b1;
					slot = i;
					r.kind = OUT_FILL;
				end
			end
		end
		if (!found)
			slot = oldest;
		r.slot = slot[SLOT_W-1:0];
		r.prev = entry_val[slot];
		entry_val[slot] = req;
		entry_stamp[slot] = req_clock;
		if (req_clock != '1)
			req_clock++;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				entry_val[i] = '0;
				entry_stamp[i] = '0;
			end
			req_clock = STAMP_W'(1);
			active_cfg = CFG_RESET;
			lookup_q.delete();
			n_in <= 0;
			n_out <= 0;
		end else begin
			if (cfg_we)
				active_cfg = cfg_wdata;
			if (req_valid && !req_stall) begin
				lookup_q.push_back(cache_lookup(request_value));
				n_in <= n_in + 1;
			end
			if (rsp_valid && !rsp_stall) begin
				n_out <= n_out + 1;
				if (lookup_q.size() == 0) begin
					flag_mismatch("result with nothing expected", previous_value, '0);
				end else begin
					want = lookup_q.pop_front();
					if (outcome != want.kind)
						flag_mismatch("outcome", VALUE_W'(outcome), VALUE_W'(want.kind));
					if (slot_index != want.slot)
						flag_mismatch("slot_index", VALUE_W'(slot_index),
							VALUE_W'(want.slot));
					if (previous_value != want.prev)
						flag_mismatch("previous_value", previous_value, want.prev);
				end
			end
		end
	end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the lru_value_cache testbench: clock, reset, request and result drivers and the
// configuration phases; the checker does prediction. Depends on lvc_pkg, lru_value_cache
// and lvc_checker.
module tb_top;
	import lvc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = CFG_RESET;
	logic req_valid = 1'b0;
	logic signed [VALUE_W-1:0] request_value = '0;
	logic rsp_stall = 1'b0;
	logic req_stall;
	logic rsp_valid;
	logic [OUTCOME_W-1:0] outcome;
	logic [SLOT_W-1:0] slot_index;
	logic signed [VALUE_W-1:0] previous_value;
	int fail_count;
	int pending;

	logic quiet = 1'b0;
	logic [VALUE_W-1:0] pool [16];
	int pool_n;
	int eff;
	int drain;
	logic [CFG_W-1:0] setting;
	int stall_left;
	int run_left;
	int rx_cycles;
	logic long_done;

	logic [VALUE_W-1:0] directed [20] = '{
		32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0001,
		32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0002, 32'h0000_0003, 32'h8000_0000,
		32'h0000_0003, 32'h7fff_ffff, 32'h0000_0004, 32'h0000_0000, 32'h0000_0002,
		32'h0000_0002, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0000
	};

	always #10 clk = ~clk;

	lru_value_cache u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.request_value  (request_value),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.outcome        (outcome),
		.slot_index     (slot_index),
		.previous_value (previous_value)
	);

	lvc_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.request_value  (request_value),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.outcome        (outcome),
		.slot_index     (slot_index),
		.previous_value (previous_value),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	task automatic send_item(input logic [VALUE_W-1:0] v);
		req_valid <= 1'b1;
		request_value <= v;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic idle_gap();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 10))
				@(posedge clk);
		end
	endtask

	task automatic write_active(input logic [CFG_W-1:0] v);
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r < 3)
			return $urandom;
		return pool[$urandom_range(0, pool_n - 1)];
	endfunction

	initial begin
		stall_left = 0;
		run_left = 0;
		rx_cycles = 0;
		long_done = 1'b0;
		forever begin
			@(posedge clk);
			rx_cycles++;
			if (quiet) begin
				rsp_stall <= 1'b0;
			end else if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else if (run_left > 0) begin
				rsp_stall <= 1'b0;
				run_left--;
			end else begin
				rsp_stall <= 1'b0;
				// hold off long enough for the request side to back up
				if (!long_done && rx_cycles > 3000) begin
					long_done = 1'b1;
					stall_left = 250;
				end else if ($urandom_range(0, 2) == 0) begin
					stall_left = $urandom_range(1, 10);
				end else begin
					run_left = $urandom_range(1, 30);
				end
			end
		end
	end

	initial begin
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < 20; i++) begin
			send_item(directed[i]);
			idle_gap();
		end
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: setting = 4'd1;
				1: setting = 4'd0;
				2: setting = 4'd15;
				3: setting = 4'd3;
				4: setting = 4'd8;
				5: setting = 4'd9;
				6: setting = 4'd5;
				7: setting = CFG_W'($urandom_range(0, 15));
				default: setting = 4'd2;
			endcase
			if (ph == 8)
				quiet <= 1'b1;
			write_active(setting);
			eff = (setting == 0) ? 1 : (setting > 8) ? 8 : setting;
			pool_n = eff + 3;
			for (int i = 0; i < pool_n; i++)
				pool[i] = $urandom;
			repeat (165) begin
				send_item(pick_value());
				idle_gap();
			end
		end
		req_valid <= 1'b0;
		drain = 0;
		@(posedge clk);
		while (pending != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (20)
			@(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#8000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
